### rtl/scpg_pkg.sv
// Shared types, constants and helper functions of the stack-code pixel generator.
// Used by scpg_ctrl, scpg_dp and stack_code_pixel_generator; depends on nothing.
package scpg_pkg;

    // Fixed point format and stack geometry.
    localparam int STACK_DEPTH        = 32;
    localparam int PTR_W              = $clog2(STACK_DEPTH);
    localparam int MAX_PROGRAM_DIGITS = 32;
    localparam int FRACTION_BITS      = 16;
    localparam int VAL_W              = FRACTION_BITS + 2;
    localparam int WIDE_W             = 40;
    localparam int DIV_STEPS          = 36;
    localparam int SQRT_STEPS         = 18;
    localparam int RECIP_SHIFT        = 28;

    typedef logic signed [VAL_W-1:0] val_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_CODE_LOW     = 3'd0;
    localparam logic [2:0] REG_CODE_HIGH    = 3'd1;
    localparam logic [2:0] REG_CODE_LENGTH  = 3'd2;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd3;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd4;

    // Program opcodes.
    localparam logic [3:0] OP_PUSH_X = 4'd0;
    localparam logic [3:0] OP_PUSH_Y = 4'd1;
    localparam logic [3:0] OP_MEAN2  = 4'd2;
    localparam logic [3:0] OP_MEAN5  = 4'd5;
    localparam logic [3:0] OP_SIN    = 4'd6;
    localparam logic [3:0] OP_COS    = 4'd7;
    localparam logic [3:0] OP_MUL    = 4'd8;
    localparam logic [3:0] OP_HYPOT  = 4'd9;

    // Datapath commands issued by the controller, one per cycle.
    typedef enum logic [5:0] {
        CMD_NOP, CMD_CAPTURE, CMD_DIVX_LOAD, CMD_DIVY_LOAD, CMD_DIV_STEP,
        CMD_SET_XF, CMD_SET_YF, CMD_WR_XF0, CMD_WR_YF1, CMD_PUSH_XF, CMD_PUSH_YF,
        CMD_POP, CMD_SUM_CLR, CMD_SUM_ADD, CMD_MEAN_MUL, CMD_PUSH_MEAN,
        CMD_A_LOAD, CMD_B_LOAD, CMD_MUL_AB, CMD_PUSH_PROD, CMD_SQ_A, CMD_SQ_B,
        CMD_SQ_LOAD, CMD_SQ_STEP, CMD_PUSH_HYP, CMD_TRIG_LOAD, CMD_MUL_UU,
        CMD_U2, CMD_MUL_PU2, CMD_HORNER, CMD_MUL_PU, CMD_PUSH_SIN, CMD_LEVEL
    } cmd_op_t;

    // Command with its small argument (mean count, cosine flag or coefficient index).
    typedef struct packed {
        cmd_op_t    op;
        logic [2:0] arg;
    } dp_cmd_t;

    // Saturate a wide signed value to the stack range.
    function automatic val_t sat_val(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] vmax;
        logic signed [WIDE_W-1:0] vmin;
        vmax = (WIDE_W'(1) <<< (VAL_W - 1)) - WIDE_W'(1);
        vmin = -(WIDE_W'(1) <<< (VAL_W - 1));
        if (v > vmax) begin
            return val_t'(vmax);
        end else if (v < vmin) begin
            return val_t'(vmin);
        end
        return val_t'(v);
    endfunction

    // Signed Q30 Taylor coefficients of sin(pi/2*u), odd index negative.
    function automatic logic signed [33:0] sin_coef(input logic [2:0] k);
        case (k)
            3'd0:    return  34'sd1686629713;
            3'd1:    return -34'sd693598668;
            3'd2:    return  34'sd85569306;
            3'd3:    return -34'sd5026995;
            3'd4:    return  34'sd172272;
            3'd5:    return -34'sd3864;
            3'd6:    return  34'sd61;
            default: return  34'sd0;
        endcase
    endfunction

    // Reciprocal of the mean count scaled by 2^RECIP_SHIFT, rounded up so that
    // the product gives the exact floor quotient for dividends below 2^26.
    function automatic logic signed [33:0] mean_recip(input logic [2:0] cnt);
        case (cnt)
            3'd2:    return 34'sd134217728;
            3'd3:    return 34'sd89478486;
            3'd4:    return 34'sd67108864;
            3'd5:    return 34'sd53687092;
            default: return 34'sd0;
        endcase
    endfunction

endpackage

### rtl/scpg_ctrl.sv
// Controller of the stack-code pixel generator: sequences scaling, program
// execution and output hand-off. Depends on scpg_pkg.
module scpg_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [63:0]            code_low,
    input  logic [63:0]            code_high,
    input  logic [5:0]             code_length,
    output scpg_pkg::dp_cmd_t      cmd
);
    import scpg_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DIVX   = 6'b000010,
        ST_DIVY   = 6'b000100,
        ST_INIT   = 6'b001000,
        ST_EXEC   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  step_reg, step_next;
    logic [4:0]  pc_reg, pc_next;
    logic        m_valid_reg, m_valid_next;
    logic [5:0]  prog_len;
    logic [127:0] code_all;
    logic [3:0]  digit;
    dp_cmd_t     exec_cmd;
    logic        exec_last;
    logic [5:0]  cnt2;
    logic [5:0]  trig_j;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    // Program length limited to the digit store.
    assign prog_len = (code_length > 6'(MAX_PROGRAM_DIGITS)) ?
                      6'(MAX_PROGRAM_DIGITS) : code_length;
    assign code_all = {code_high, code_low};
    assign digit    = code_all[{pc_reg, 2'b00} +: 4];
    assign cnt2     = {2'b00, digit[2:0], 1'b0};
    assign trig_j   = step_reg - 6'd4;

    // Micro-sequence of one opcode, indexed by the step counter.
    always_comb begin
        exec_cmd  = '{op: CMD_NOP, arg: 3'd0};
        exec_last = 1'b0;
        case (digit) inside
            OP_PUSH_X: begin
                exec_cmd.op = CMD_PUSH_XF;
                exec_last   = 1'b1;
            end
            OP_PUSH_Y: begin
                exec_cmd.op = CMD_PUSH_YF;
                exec_last   = 1'b1;
            end
            [OP_MEAN2:OP_MEAN5]: begin
                if (step_reg == 6'd0) begin
                    exec_cmd.op = CMD_SUM_CLR;
                end else if (step_reg <= cnt2) begin
                    exec_cmd.op = step_reg[0] ? CMD_POP : CMD_SUM_ADD;
                end else if (step_reg == cnt2 + 6'd1) begin
                    // Divide by the count through a reciprocal multiply.
                    exec_cmd.op  = CMD_MEAN_MUL;
                    exec_cmd.arg = digit[2:0];
                end else begin
                    exec_cmd.op = CMD_PUSH_MEAN;
                    exec_last   = 1'b1;
                end
            end
            OP_SIN, OP_COS: begin
                if (step_reg == 6'd0) begin
                    exec_cmd.op = CMD_POP;
                end else if (step_reg == 6'd1) begin
                    exec_cmd.op  = CMD_TRIG_LOAD;
                    exec_cmd.arg = {2'b00, (digit == OP_COS)};
                end else if (step_reg == 6'd2) begin
                    exec_cmd.op = CMD_MUL_UU;
                end else if (step_reg == 6'd3) begin
                    exec_cmd.op = CMD_U2;
                end else if (step_reg <= 6'd15) begin
                    // Six Horner rounds, coefficient index counting down from five.
                    exec_cmd.op  = trig_j[0] ? CMD_HORNER : CMD_MUL_PU2;
                    exec_cmd.arg = 3'd5 - trig_j[3:1];
                end else if (step_reg == 6'd16) begin
                    exec_cmd.op = CMD_MUL_PU;
                end else begin
                    exec_cmd.op = CMD_PUSH_SIN;
                    exec_last   = 1'b1;
                end
            end
            OP_MUL, OP_HYPOT: begin
                case (step_reg)
                    6'd0, 6'd2: exec_cmd.op = CMD_POP;
                    6'd1:       exec_cmd.op = CMD_A_LOAD;
                    6'd3:       exec_cmd.op = CMD_B_LOAD;
                    default: begin
                        if (digit == OP_MUL) begin
                            if (step_reg == 6'd4) begin
                                exec_cmd.op = CMD_MUL_AB;
                            end else begin
                                exec_cmd.op = CMD_PUSH_PROD;
                                exec_last   = 1'b1;
                            end
                        end else if (step_reg == 6'd4) begin
                            exec_cmd.op = CMD_SQ_A;
                        end else if (step_reg == 6'd5) begin
                            exec_cmd.op = CMD_SQ_B;
                        end else if (step_reg == 6'd6) begin
                            exec_cmd.op = CMD_SQ_LOAD;
                        end else if (step_reg <= 6'd6 + 6'(SQRT_STEPS)) begin
                            exec_cmd.op = CMD_SQ_STEP;
                        end else begin
                            exec_cmd.op = CMD_PUSH_HYP;
                            exec_last   = 1'b1;
                        end
                    end
                endcase
            end
            default: begin
                exec_last = 1'b1;
            end
        endcase
    end

    // Main sequencer.
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg + 6'd1;
        pc_next      = pc_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        cmd          = '{op: CMD_NOP, arg: 3'd0};
        case (state_reg)
            ST_IDLE: begin
                step_next = 6'd0;
                if (s_tvalid) begin
                    cmd.op     = CMD_CAPTURE;
                    state_next = ST_DIVX;
                end
            end
            ST_DIVX, ST_DIVY: begin
                if (step_reg == 6'd0) begin
                    cmd.op = (state_reg == ST_DIVX) ? CMD_DIVX_LOAD : CMD_DIVY_LOAD;
                end else if (step_reg <= 6'(DIV_STEPS)) begin
                    cmd.op = CMD_DIV_STEP;
                end else begin
                    cmd.op     = (state_reg == ST_DIVX) ? CMD_SET_XF : CMD_SET_YF;
                    step_next  = 6'd0;
                    state_next = (state_reg == ST_DIVX) ? ST_DIVY : ST_INIT;
                end
            end
            ST_INIT: begin
                if (step_reg == 6'd0) begin
                    cmd.op = CMD_WR_XF0;
                end else begin
                    cmd.op     = CMD_WR_YF1;
                    step_next  = 6'd0;
                    pc_next    = 5'd0;
                    state_next = (prog_len == 6'd0) ? ST_FINISH : ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd = exec_cmd;
                if (exec_last) begin
                    step_next = 6'd0;
                    pc_next   = pc_reg + 5'd1;
                    if ({1'b0, pc_reg} + 6'd1 == prog_len) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (step_reg == 6'd0) begin
                    cmd.op = CMD_POP;
                end else if (!m_valid_reg || m_tready) begin
                    // Output register is free: load the level and release the input.
                    cmd.op       = CMD_LEVEL;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    step_next = step_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= 6'd0;
            pc_reg      <= 5'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### rtl/scpg_dp.sv
// Datapath of the stack-code pixel generator: value stack, iterative divider,
// square root, shared multiplier and output level. Depends on scpg_pkg.
module scpg_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  scpg_pkg::dp_cmd_t   cmd,
    input  logic [31:0]         in_data,
    input  logic [15:0]         image_width,
    input  logic [15:0]         image_height,
    output logic [15:0]         level
);
    import scpg_pkg::*;

    // Stack memory with per-entry valid bits; an unwritten entry reads as zero.
    val_t                    mem [STACK_DEPTH];
    logic [STACK_DEPTH-1:0]  valid_reg;
    logic [PTR_W-1:0]        top_reg;
    val_t                    rd_data_reg;

    logic [15:0]  x_reg, y_reg;
    val_t         xf_reg, yf_reg, a_reg, b_reg;
    logic signed [20:0] sum_reg;
    logic [35:0]  div_num_reg;
    logic [16:0]  div_rem_reg, div_den_reg;
    logic [35:0]  sq_n_reg, sq_res_reg, sq_bit_reg;
    logic [30:0]  u_reg, u2_reg;
    logic signed [33:0] p_reg;
    logic signed [67:0] prod_reg;
    logic [1:0]   quad_reg;
    logic [15:0]  level_reg;

    logic [15:0]  w_eff, h_eff;
    logic signed [WIDE_W-1:0] quo_s;
    logic         wr_en;
    logic [PTR_W-1:0] wr_addr;
    val_t         wr_data;
    logic         push_en;
    val_t         push_val;
    logic signed [33:0] mul_a, mul_b;
    logic         mul_en;
    logic [17:0]  rem_sh;
    logic [36:0]  sq_trial;
    logic signed [67:0] sin_wide;
    logic signed [WIDE_W-1:0] sin_v;
    logic [16:0]  phase;
    logic [29:0]  frac_r;
    logic signed [35:0] mean_num;
    logic [16:0]  lvl_off;
    logic [32:0]  lvl_prod;

    assign level = level_reg;
    assign w_eff = (image_width == 16'd0) ? 16'd1 : image_width;
    assign h_eff = (image_height == 16'd0) ? 16'd1 : image_height;
    assign quo_s = $signed({4'b0, div_num_reg});

    // Sine result: round Q30 to the value format, clamp to [0,1], apply quadrant sign.
    assign sin_wide = ((prod_reg >>> 30) + 68'sd8192) >>> 14;
    always_comb begin
        sin_v = WIDE_W'(sin_wide);
        if (sin_v > 40'sd65536) begin
            sin_v = 40'sd65536;
        end else if (sin_v < 40'sd0) begin
            sin_v = 40'sd0;
        end
        if (quad_reg[1]) begin
            sin_v = -sin_v;
        end
    end

    // Value pushed by the current command.
    always_comb begin
        push_en  = 1'b1;
        push_val = '0;
        case (cmd.op)
            CMD_PUSH_XF:   push_val = xf_reg;
            CMD_PUSH_YF:   push_val = yf_reg;
            CMD_PUSH_MEAN: push_val = sat_val(WIDE_W'(prod_reg >>> RECIP_SHIFT)
                                              - 40'sd2097152);
            CMD_PUSH_PROD: push_val = sat_val(WIDE_W'((prod_reg + 68'sd32768) >>> 16));
            CMD_PUSH_HYP:  push_val = sat_val($signed({4'b0, 36'((37'(sq_res_reg) + 37'd1) >> 1)}));
            CMD_PUSH_SIN:  push_val = sat_val(sin_v);
            default:       push_en  = 1'b0;
        endcase
    end

    // Single stack write port.
    always_comb begin
        wr_en   = push_en;
        wr_addr = top_reg + PTR_W'(1);
        wr_data = push_val;
        case (cmd.op)
            CMD_WR_XF0: begin
                wr_en   = 1'b1;
                wr_addr = PTR_W'(0);
                wr_data = xf_reg;
            end
            CMD_WR_YF1: begin
                wr_en   = 1'b1;
                wr_addr = PTR_W'(1);
                wr_data = yf_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.op == CMD_POP) begin
            rd_data_reg <= valid_reg[top_reg] ? mem[top_reg] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            top_reg   <= PTR_W'(1);
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (push_en) begin
                top_reg <= top_reg + PTR_W'(1);
            end else if (cmd.op == CMD_POP) begin
                top_reg <= top_reg - PTR_W'(1);
            end else if (cmd.op == CMD_WR_YF1) begin
                top_reg <= PTR_W'(1);
            end
        end
    end

    // Shared multiplier operands.
    always_comb begin
        mul_en = 1'b1;
        mul_a  = 34'(a_reg);
        mul_b  = 34'(b_reg);
        case (cmd.op)
            CMD_MUL_AB: ;
            CMD_SQ_A:   mul_b = 34'(a_reg);
            CMD_SQ_B:   mul_a = 34'(b_reg);
            CMD_MEAN_MUL: begin
                // Offset numerator halved, times the scaled reciprocal of the count.
                mul_a = $signed({9'b0, mean_num[25:1]});
                mul_b = mean_recip(cmd.arg);
            end
            CMD_MUL_UU: begin
                mul_a = $signed({3'b0, u_reg});
                mul_b = $signed({3'b0, u_reg});
            end
            CMD_MUL_PU2: begin
                mul_a = p_reg;
                mul_b = $signed({3'b0, u2_reg});
            end
            CMD_MUL_PU: begin
                mul_a = p_reg;
                mul_b = $signed({3'b0, u_reg});
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // Divider, square root, sum and trig registers.
    assign rem_sh   = {div_rem_reg, div_num_reg[35]};
    assign sq_trial = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
    assign phase    = rd_data_reg[16:0] + (cmd.arg[0] ? 17'h08000 : 17'h00000);
    assign frac_r   = {phase[14:0], 15'b0};
    // Twice the sum plus the count, offset by count * 2^22 to stay positive.
    assign mean_num = (36'(sum_reg) <<< 1) + $signed({33'b0, cmd.arg})
                      + $signed({11'b0, cmd.arg, 22'b0});
    assign lvl_off  = 17'(rd_data_reg + 18'sd65536);
    assign lvl_prod = 33'(lvl_off) * 33'd65535;

    always_ff @(posedge aclk) begin
        case (cmd.op)
            CMD_CAPTURE: begin
                x_reg <= in_data[15:0];
                y_reg <= in_data[31:16];
            end
            CMD_DIVX_LOAD: begin
                div_num_reg <= 36'({x_reg, 18'b0}) + 36'(w_eff);
                div_den_reg <= {w_eff, 1'b0};
                div_rem_reg <= '0;
            end
            CMD_DIVY_LOAD: begin
                div_num_reg <= 36'({y_reg, 18'b0}) + 36'(h_eff);
                div_den_reg <= {h_eff, 1'b0};
                div_rem_reg <= '0;
            end
            CMD_DIV_STEP: begin
                // One restoring step: quotient bits enter at the bottom of the numerator.
                if (rem_sh >= {1'b0, div_den_reg}) begin
                    div_rem_reg <= 17'(rem_sh - {1'b0, div_den_reg});
                    div_num_reg <= {div_num_reg[34:0], 1'b1};
                end else begin
                    div_rem_reg <= rem_sh[16:0];
                    div_num_reg <= {div_num_reg[34:0], 1'b0};
                end
            end
            CMD_SET_XF:  xf_reg  <= sat_val(quo_s - 40'sd65536);
            CMD_SET_YF:  yf_reg  <= sat_val(40'sd65536 - quo_s);
            CMD_SUM_CLR: sum_reg <= '0;
            CMD_SUM_ADD: sum_reg <= sum_reg + 21'(rd_data_reg);
            CMD_A_LOAD:  a_reg   <= rd_data_reg;
            CMD_B_LOAD:  b_reg   <= rd_data_reg;
            CMD_SQ_B:    sq_n_reg <= prod_reg[35:0];
            CMD_SQ_LOAD: begin
                sq_n_reg   <= sq_n_reg + prod_reg[35:0];
                sq_res_reg <= '0;
                sq_bit_reg <= 36'(1) << 34;
            end
            CMD_SQ_STEP: begin
                if ({1'b0, sq_n_reg} >= sq_trial) begin
                    sq_n_reg   <= sq_n_reg - sq_trial[35:0];
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            CMD_TRIG_LOAD: begin
                quad_reg <= phase[16:15];
                u_reg    <= phase[15] ? (31'h40000000 - {1'b0, frac_r}) : {1'b0, frac_r};
            end
            CMD_U2: begin
                u2_reg <= prod_reg[60:30];
                p_reg  <= sin_coef(3'd6);
            end
            CMD_HORNER: p_reg <= 34'(prod_reg >>> 30) + sin_coef(cmd.arg);
            CMD_LEVEL: begin
                // Clamp the top of stack to [-1,1] and map it to 16 bits.
                if (rd_data_reg >= 18'sd65536) begin
                    level_reg <= 16'hFFFF;
                end else if (rd_data_reg <= -18'sd65536) begin
                    level_reg <= 16'h0000;
                end else begin
                    level_reg <= lvl_prod[32:17];
                end
            end
            default: ;
        endcase
    end

endmodule

### rtl/stack_code_pixel_generator.sv
// Top level of the stack-code pixel generator: configuration registers and the
// controller and datapath instances. Depends on scpg_pkg, scpg_ctrl, scpg_dp.
//
// Usage: each input beat on the s_ channel carries one pixel coordinate; the
// block runs the configured program of up to 32 opcodes on a 32-entry wrapping
// value stack and returns one 16-bit level as one beat on the m_ channel.
// Configuration is to be written through cfg_wr_en / cfg_index / cfg_wdata
// only while the block is idle (the block does not enforce this); index 0
// and 1 hold the opcode nibbles, 2 the program length, 3 and 4 the image
// width and height. Each item takes one capture, two coordinate divisions on
// the iterative divider, two stack initialization writes and the output pop
// and level load, plus the work of each opcode: the mean of n uses a
// reciprocal multiply on the shared multiplier, sin/cos takes eight passes of
// the shared multiplier and the half hypotenuse an 18-step square root.
// One item is worked on at a time; the next is taken once the level is loaded
// into the output register, so a stalled receiver holds only the finished beat.
// A stall longer than the next item's work holds that item at its final step.
// Reset clears the stack valid bits (the stack reads as zero) and the output
// valid flag, sets the stack pointer to 1 and loads the configuration reset values.
module stack_code_pixel_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // x_coord [15:0], y_coord [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // level [15:0]
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);
    import scpg_pkg::*;

    logic [63:0] code_low_reg, code_high_reg;
    logic [5:0]  code_length_reg;
    logic [15:0] image_width_reg, image_height_reg;
    dp_cmd_t     cmd;

    // Configuration register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_low_reg     <= '0;
            code_high_reg    <= '0;
            code_length_reg  <= '0;
            image_width_reg  <= 16'd1;
            image_height_reg <= 16'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CODE_LOW:     code_low_reg     <= cfg_wdata;
                REG_CODE_HIGH:    code_high_reg    <= cfg_wdata;
                REG_CODE_LENGTH:  code_length_reg  <= cfg_wdata[5:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[15:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    scpg_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .code_low    (code_low_reg),
        .code_high   (code_high_reg),
        .code_length (code_length_reg),
        .cmd         (cmd)
    );

    scpg_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .in_data      (s_tdata),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .level        (m_tdata)
    );

endmodule

### tb/scpg_checker.sv
// Checker for the stack-code pixel generator: watches the input, result and
// configuration ports, predicts each level and compares. Depends on scpg_pkg.
`timescale 1ns / 1ps

module scpg_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    output int          mismatches,
    output int          pending
);
    import scpg_pkg::*;

    localparam longint ONE_FX  = 64'sd1 <<< FRACTION_BITS;
    localparam longint VAL_MAX = (64'sd1 <<< (FRACTION_BITS + 1)) - 1;
    localparam longint VAL_MIN = -(64'sd1 <<< (FRACTION_BITS + 1));

    // Predictor copy of configuration and stack.
    logic [63:0] prog_lo, prog_hi;
    logic [5:0]  prog_len;
    logic [15:0] img_w, img_h;
    longint      stack_mem [STACK_DEPTH];
    int          sp;
    logic [15:0] level_queue [$];

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint clip(longint v);
        return v > VAL_MAX ? VAL_MAX : (v < VAL_MIN ? VAL_MIN : v);
    endfunction

    function automatic longint coef(int k);
        longint mag [7];
        mag = '{1686629713, 693598668, 85569306, 5026995, 172272, 3864, 61};
        return (k % 2) ? -mag[k] : mag[k];
    endfunction

    // sin(pi*(a+offset)) with a polynomial on one quadrant in Q30.
    function automatic longint sin_pi_fx(longint a, longint offset);
        logic [63:0] t, ph;
        int          quad;
        longint      r, u, u2, p, s, v;
        t  = (a + offset) & ((64'd1 << (FRACTION_BITS + 1)) - 1);
        ph = t << (30 - FRACTION_BITS);
        quad = int'((ph >> 29) & 3);
        r = longint'(ph & ((64'd1 << 29) - 1)) * 2;
        u = (quad & 1) ? ((64'sd1 <<< 30) - r) : r;
        u2 = fdiv(u * u, 64'sd1 <<< 30);
        p = coef(6);
        for (int k = 5; k >= 0; k--) p = fdiv(p * u2, 64'sd1 <<< 30) + coef(k);
        s = fdiv(p * u, 64'sd1 <<< 30);
        v = fdiv(s + (64'sd1 <<< (30 - FRACTION_BITS - 1)), 64'sd1 <<< (30 - FRACTION_BITS));
        if (v > ONE_FX) v = ONE_FX;
        if (v < 0) v = 0;
        return (quad & 2) ? -v : v;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint res, bitv;
        res = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > n) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >>> 1) + bitv;
            end else begin
                res = res >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    task automatic push_val(longint v);
        sp = (sp + 1) % STACK_DEPTH;
        stack_mem[sp] = clip(v);
    endtask

    task automatic pop_val(output longint v);
        v = stack_mem[sp];
        sp = (sp + STACK_DEPTH - 1) % STACK_DEPTH;
    endtask

    // Runs the program for one pixel and returns its level.
    task automatic compute_level(input logic [15:0] xi, input logic [15:0] yi,
                                 output logic [15:0] lvl);
        longint w, h, xf, yf, a, b, sum;
        int     n, cnt;
        logic [3:0] op;
        w = (img_w == 16'd0) ? 64'sd1 : longint'(img_w);
        h = (img_h == 16'd0) ? 64'sd1 : longint'(img_h);
        xf = clip((4 * longint'(xi) * ONE_FX + w) / (2 * w) - ONE_FX);
        yf = clip(ONE_FX - (4 * longint'(yi) * ONE_FX + h) / (2 * h));
        n = (int'(prog_len) > MAX_PROGRAM_DIGITS) ? MAX_PROGRAM_DIGITS : int'(prog_len);
        stack_mem[0] = xf;
        stack_mem[1] = yf;
        sp = 1;
        for (int i = 0; i < n; i++) begin
            op = i < 16 ? prog_lo[4*i +: 4] : prog_hi[4*(i-16) +: 4];
            if (op == OP_PUSH_X) begin
                push_val(xf);
            end else if (op == OP_PUSH_Y) begin
                push_val(yf);
            end else if (op >= OP_MEAN2 && op <= OP_MEAN5) begin
                cnt = int'(op);
                sum = 0;
                for (int k = 0; k < cnt; k++) begin
                    pop_val(a);
                    sum += a;
                end
                push_val(fdiv(2 * sum + cnt, 2 * cnt));
            end else if (op == OP_SIN || op == OP_COS) begin
                pop_val(a);
                push_val(sin_pi_fx(a, op == OP_COS ? ONE_FX / 2 : 0));
            end else if (op == OP_MUL) begin
                pop_val(a);
                pop_val(b);
                push_val(fdiv(a * b + ONE_FX / 2, ONE_FX));
            end else if (op == OP_HYPOT) begin
                pop_val(a);
                pop_val(b);
                push_val((int_sqrt(a * a + b * b) + 1) >>> 1);
            end
        end
        pop_val(a);
        if (a >= ONE_FX) lvl = 16'hFFFF;
        else if (a <= -ONE_FX) lvl = 16'h0000;
        else lvl = 16'(((a + ONE_FX) * 65535) >>> (FRACTION_BITS + 1));
    endtask

    assign pending = level_queue.size();

    always @(posedge aclk) begin
        logic [15:0] lvl;
        logic [15:0] want;
        if (!aresetn) begin
            prog_lo  <= '0;
            prog_hi  <= '0;
            prog_len <= '0;
            img_w    <= 16'd1;
            img_h    <= 16'd1;
            for (int i = 0; i < STACK_DEPTH; i++) stack_mem[i] = 0;
            sp = 1;
            level_queue.delete();
            mismatches <= 0;
        end else begin
            // Configuration writes.
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CODE_LOW:     prog_lo  <= cfg_wdata;
                    REG_CODE_HIGH:    prog_hi  <= cfg_wdata;
                    REG_CODE_LENGTH:  prog_len <= cfg_wdata[5:0];
                    REG_IMAGE_WIDTH:  img_w    <= cfg_wdata[15:0];
                    REG_IMAGE_HEIGHT: img_h    <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            // Accepted input beat.
            if (s_tvalid && s_tready) begin
                compute_level(s_tdata[15:0], s_tdata[31:16], lvl);
                level_queue.push_back(lvl);
            end
            // Accepted result beat.
            if (m_tvalid && m_tready) begin
                if (level_queue.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result beat: level %0d", m_tdata);
                    mismatches <= mismatches + 1;
                end else begin
                    want = level_queue.pop_front();
                    if (want !== m_tdata) begin
                        if (mismatches < 10)
                            $display("level mismatch: expected %0d actual %0d",
                                     want, m_tdata);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

### tb/tb.sv
// Testbench top for the stack-code pixel generator: clock, reset, stimulus and
// verdict. Depends on scpg_pkg, scpg_checker and the block's RTL.
`timescale 1ns / 1ps

module tb;
    import scpg_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;
    int          mismatches;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;

    always #5 aclk = ~aclk;

    stack_code_pixel_generator dut (.*);

    scpg_checker checker_i (.*);

    // Receiver stalls at random.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Drives one register write; the caller drops the write enable afterward.
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic load_program(logic [63:0] lo, logic [63:0] hi, logic [5:0] len,
                                logic [15:0] w, logic [15:0] h);
        write_reg(REG_CODE_LOW, lo);
        write_reg(REG_CODE_HIGH, hi);
        write_reg(REG_CODE_LENGTH, 64'(len));
        write_reg(REG_IMAGE_WIDTH, 64'(w));
        write_reg(REG_IMAGE_HEIGHT, 64'(h));
        cfg_wr_en <= 1'b0;
    endtask

    // Sends one pixel beat, with a random gap before it; valid stays high
    // after the accepting edge until the next beat or the drain replaces it.
    task automatic send_pixel(logic [15:0] x, logic [15:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Waits until every level is back, then lets the block settle.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64;
        return {$urandom, $urandom};
    endfunction

    // Random digits weighted toward the working opcodes.
    function automatic logic [63:0] rand_code;
        logic [63:0] c;
        for (int i = 0; i < 16; i++)
            c[4*i +: 4] = ($urandom_range(9) == 0) ? 4'($urandom_range(10, 15))
                                                   : 4'($urandom_range(9));
        return c;
    endfunction

    function automatic logic [15:0] rand_size;
        case ($urandom_range(5))
            0: return 16'hFFFF;
            1: return 16'd0;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 512));
        endcase
    endfunction

    initial begin
        logic [15:0] w, h;
        send_idle_pct = 19;
        recv_idle_pct = 62;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty program at reset values, then extreme pixels.
        send_pixel(16'd0, 16'd0);
        send_pixel(16'hFFFF, 16'hFFFF);
        drain();
        // Every opcode at least once, including idle nibbles and wrapping pops.
        load_program(64'hFEDC_BA98_7654_3210, 64'h9876_5432_1010_6701, 6'd63,
                     16'd100, 16'd80);
        send_pixel(16'd0, 16'd0);
        send_pixel(16'd50, 16'd40);
        send_pixel(16'd99, 16'd79);
        send_pixel(16'hFFFF, 16'hFFFF);
        drain();
        load_program(64'h0000_0000_0098_7610, 64'h0, 6'd32, 16'hFFFF, 16'd0);
        for (int i = 0; i < 6; i++) send_pixel(16'($urandom), 16'($urandom));
        drain();
        load_program(64'h0000_0000_0000_5432, 64'hFFFF_FFFF_FFFF_FFFF, 6'd4,
                     16'd1, 16'd1);
        for (int i = 0; i < 6; i++) send_pixel(16'($urandom_range(2)), 16'($urandom_range(2)));
        drain();

        // Random phases with new programs and sizes.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 19 : (ph == 1 ? 62 : 0);
            recv_idle_pct = (ph == 0) ? 62 : (ph == 1 ? 19 : 0);
            for (int blk = 0; blk < 10; blk++) begin
                w = rand_size();
                h = rand_size();
                load_program(($urandom_range(3) == 0) ? rand64() : rand_code(),
                             ($urandom_range(3) == 0) ? rand64() : rand_code(),
                             6'($urandom_range(63)), w, h);
                for (int i = 0; i < 25; i++) begin
                    if ($urandom_range(3) == 0)
                        send_pixel(16'($urandom), 16'($urandom));
                    else
                        send_pixel(16'($urandom_range(w)), 16'($urandom_range(h)));
                end
                drain();
            end
        end

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
